// ===== rtl/rgb_hsv_pixel_converter_assert.svh =====
// Assertion macros for the RGB/HSV pixel converter.
`ifndef RGB_HSV_PIXEL_CONVERTER_ASSERT_SVH
`define RGB_HSV_PIXEL_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define RHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhc: same-cycle check failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhc: next-cycle check failed");

`endif

// ===== rtl/rhc_pkg.sv =====
// Types, constants and helpers for the RGB/HSV pixel converter.
package rhc_pkg;

  localparam int CB = 16;
  localparam int W  = CB + 3;
  localparam int DW = 2 * CB + 3;

  localparam logic [CB-1:0] FS    = {CB{1'b1}};
  localparam logic [W-1:0]  FS_W  = W'(FS);
  localparam logic [W-1:0]  FS_X2 = FS_W << 1;
  localparam logic [W-1:0]  FS_X3 = FS_X2 + FS_W;
  localparam logic [W-1:0]  FS_X4 = FS_W << 2;
  localparam logic [W-1:0]  FS_X5 = FS_X4 + FS_W;

  localparam logic FUNC_TO_HSV = 1'b0;
  localparam logic FUNC_TO_RGB = 1'b1;

  localparam logic [2:0] SEXT_RED_YEL = 3'd0;
  localparam logic [2:0] SEXT_YEL_GRN = 3'd1;
  localparam logic [2:0] SEXT_GRN_CYN = 3'd2;
  localparam logic [2:0] SEXT_CYN_BLU = 3'd3;
  localparam logic [2:0] SEXT_BLU_MAG = 3'd4;
  localparam logic [2:0] SEXT_MAG_RED = 3'd5;

  typedef struct packed {
    logic          func;
    logic [CB-1:0] chan_a;
    logic [CB-1:0] chan_b;
    logic [CB-1:0] chan_c;
  } pix_in_t;

  typedef struct packed {
    logic [CB-1:0] res_a;
    logic [CB-1:0] res_b;
    logic [CB-1:0] res_c;
  } pix_out_t;

  typedef struct packed {
    logic          func;
    logic [W-1:0]  s_rem;
    logic [W-1:0]  s_div;
    logic [CB-1:0] s_lo;
    logic [CB-1:0] s_q;
    logic          s_zero;
    logic [W-1:0]  h_rem;
    logic [W-1:0]  h_div;
    logic [CB-1:0] h_lo;
    logic [CB-1:0] h_q;
    logic          h_zero;
    logic [CB-1:0] v;
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
  } dstage_t;

  function automatic logic [CB-1:0] fs_div(input logic [2*CB-1:0] p);
    logic [CB:0] q0;
    logic [CB:0] rr;
    q0 = {1'b0, p[2*CB-1:CB]};
    rr = {1'b0, p[CB-1:0]} + q0;
    if (rr >= {FS, 1'b0}) begin
      return CB'(q0 + (CB+1)'(2));
    end else if (rr >= {1'b0, FS}) begin
      return CB'(q0 + (CB+1)'(1));
    end else begin
      return CB'(q0);
    end
  endfunction

  function automatic dstage_t div_step(input dstage_t a);
    dstage_t   o;
    logic [W:0] ts;
    logic [W:0] th;
    o  = a;
    ts = {a.s_rem, a.s_lo[CB-1]};
    th = {a.h_rem, a.h_lo[CB-1]};
    if (ts >= {1'b0, a.s_div}) begin
      o.s_rem = W'(ts - {1'b0, a.s_div});
      o.s_q   = {a.s_q[CB-2:0], 1'b1};
    end else begin
      o.s_rem = ts[W-1:0];
      o.s_q   = {a.s_q[CB-2:0], 1'b0};
    end
    if (th >= {1'b0, a.h_div}) begin
      o.h_rem = W'(th - {1'b0, a.h_div});
      o.h_q   = {a.h_q[CB-2:0], 1'b1};
    end else begin
      o.h_rem = th[W-1:0];
      o.h_q   = {a.h_q[CB-2:0], 1'b0};
    end
    o.s_lo = {a.s_lo[CB-2:0], 1'b0};
    o.h_lo = {a.h_lo[CB-2:0], 1'b0};
    return o;
  endfunction

endpackage

// ===== rtl/rgb_hsv_pixel_converter.sv =====
// Top level of the pipelined RGB/HSV pixel converter.
//
//   channel | signals                      | carries
//   --------+------------------------------+------------------------------
//   input   | in_valid, in_stall, in_data  | func, chan_a, chan_b, chan_c
//   output  | out_valid, out_stall, out_data | res_a, res_b, res_c
//
// One pixel per cycle unless out_stall holds a result; a 16-stage restoring
// divider for S and H follows five front stages, then one output register.
// The whole pipeline advances together; out_stall with a held result freezes
// every stage and raises in_stall in the same cycle.
// rst clears all valid bits; no clearing pass.
`include "rgb_hsv_pixel_converter_assert.svh"

module rgb_hsv_pixel_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rhc_pkg::pix_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rhc_pkg::pix_out_t  out_data
);

  localparam int CB = rhc_pkg::CB;
  localparam int W  = rhc_pkg::W;
  localparam int DW = rhc_pkg::DW;

  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage 1
  logic             valid1;
  rhc_pkg::pix_in_t in1;

  // stage 2
  logic              valid2;
  logic              func2;
  logic [CB-1:0]     hv2, hc2;
  logic [W-1:0]      hnum2;
  logic [2*CB-1:0]   rvs2;
  logic [CB-1:0]     rt2, rv2;
  logic [2:0]        rsext2;

  logic [CB-1:0]     mx, mn, cv;
  logic [W-1:0]      c_w, num, h6, r2;
  logic [2:0]        sext;
  logic [CB-1:0]     tt;

  // stages 3..5
  logic              valid3, valid4, valid5;
  rhc_pkg::dstage_t  ds3, ds4, ds5, ds3_next, ds5_next;
  logic [CB-1:0]     cc3, m3, t3, v3, m4, v4;
  logic [2:0]        sext3, sext4;
  logic [2*CB-1:0]   prod4;
  logic [DW-1:0]     sd, hd;
  logic [CB-1:0]     cc, xx, mdv;

  // divider stages
  logic              dvalid [CB];
  rhc_pkg::dstage_t  dst    [CB];

  logic              out_func;
  rhc_pkg::pix_out_t out_next;
  logic              hsv_black;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (advance) begin
      valid1 <= in_valid;
    end
    if (advance) begin
      in1 <= in_data;
    end
  end

  always_comb begin
    mx = (in1.chan_a > in1.chan_b) ? in1.chan_a : in1.chan_b;
    mx = (mx > in1.chan_c) ? mx : in1.chan_c;
    mn = (in1.chan_a < in1.chan_b) ? in1.chan_a : in1.chan_b;
    mn = (mn < in1.chan_c) ? mn : in1.chan_c;
    cv = mx - mn;
    c_w = W'(cv);
    if (mx == in1.chan_a) begin
      if (in1.chan_b >= in1.chan_c) begin
        num = W'(in1.chan_b - in1.chan_c);
      end else begin
        num = (c_w << 2) + (c_w << 1) - W'(in1.chan_c - in1.chan_b);
      end
    end else if (mx == in1.chan_b) begin
      num = (c_w << 1) + W'(in1.chan_c) - W'(in1.chan_a);
    end else begin
      num = (c_w << 2) + W'(in1.chan_a) - W'(in1.chan_b);
    end

    h6 = (W'(in1.chan_a) << 2) + (W'(in1.chan_a) << 1);
    priority if (h6 >= rhc_pkg::FS_X5) sext = rhc_pkg::SEXT_MAG_RED;
    else if (h6 >= rhc_pkg::FS_X4)     sext = rhc_pkg::SEXT_BLU_MAG;
    else if (h6 >= rhc_pkg::FS_X3)     sext = rhc_pkg::SEXT_CYN_BLU;
    else if (h6 >= rhc_pkg::FS_X2)     sext = rhc_pkg::SEXT_GRN_CYN;
    else if (h6 >= rhc_pkg::FS_W)      sext = rhc_pkg::SEXT_YEL_GRN;
    else                               sext = rhc_pkg::SEXT_RED_YEL;
    if (sext[2]) begin
      r2 = h6 - rhc_pkg::FS_X4;
    end else if (sext[1]) begin
      r2 = h6 - rhc_pkg::FS_X2;
    end else begin
      r2 = h6;
    end
    if (r2 >= rhc_pkg::FS_W) begin
      tt = CB'(r2 - rhc_pkg::FS_W);
    end else begin
      tt = CB'(rhc_pkg::FS_W - r2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (advance) begin
      valid2 <= valid1;
    end
    if (advance) begin
      func2  <= in1.func;
      hv2    <= mx;
      hc2    <= cv;
      hnum2  <= num;
      rvs2   <= (2*CB)'(in1.chan_b) * (2*CB)'(in1.chan_c);
      rt2    <= tt;
      rv2    <= in1.chan_c;
      rsext2 <= sext;
    end
  end

  always_comb begin
    sd = (DW'(hc2) << CB) - DW'(hc2);
    hd = (DW'(hnum2) << CB) - DW'(hnum2);
    ds3_next        = '0;
    ds3_next.func   = func2;
    ds3_next.s_div  = W'(hv2);
    ds3_next.s_rem  = sd[DW-1:CB];
    ds3_next.s_lo   = sd[CB-1:0];
    ds3_next.s_zero = (hv2 == '0);
    ds3_next.h_div  = (W'(hc2) << 2) + (W'(hc2) << 1);
    ds3_next.h_rem  = hd[DW-1:CB];
    ds3_next.h_lo   = hd[CB-1:0];
    ds3_next.h_zero = (hc2 == '0);
    ds3_next.v      = hv2;
    cc              = rhc_pkg::fs_div(rvs2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
      valid5 <= 1'b0;
    end else if (advance) begin
      valid3 <= valid2;
      valid4 <= valid3;
      valid5 <= valid4;
    end
    if (advance) begin
      ds3   <= ds3_next;
      cc3   <= cc;
      m3    <= rv2 - cc;
      t3    <= rt2;
      v3    <= rv2;
      sext3 <= rsext2;
      ds4   <= ds3;
      prod4 <= (2*CB)'(cc3) * (2*CB)'(rhc_pkg::FS - t3);
      m4    <= m3;
      v4    <= v3;
      sext4 <= sext3;
      ds5   <= ds5_next;
    end
  end

  always_comb begin
    xx       = rhc_pkg::fs_div(prod4);
    mdv      = xx + m4;
    ds5_next = ds4;
    unique case (sext4)
      rhc_pkg::SEXT_RED_YEL: begin
        ds5_next.r = v4;  ds5_next.g = mdv; ds5_next.b = m4;
      end
      rhc_pkg::SEXT_YEL_GRN: begin
        ds5_next.r = mdv; ds5_next.g = v4;  ds5_next.b = m4;
      end
      rhc_pkg::SEXT_GRN_CYN: begin
        ds5_next.r = m4;  ds5_next.g = v4;  ds5_next.b = mdv;
      end
      rhc_pkg::SEXT_CYN_BLU: begin
        ds5_next.r = m4;  ds5_next.g = mdv; ds5_next.b = v4;
      end
      rhc_pkg::SEXT_BLU_MAG: begin
        ds5_next.r = mdv; ds5_next.g = m4;  ds5_next.b = v4;
      end
      default: begin
        ds5_next.r = v4;  ds5_next.g = m4;  ds5_next.b = mdv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CB; k++) begin
        dvalid[k] <= 1'b0;
      end
    end else if (advance) begin
      dvalid[0] <= valid5;
      for (int k = 1; k < CB; k++) begin
        dvalid[k] <= dvalid[k-1];
      end
    end
    if (advance) begin
      dst[0] <= rhc_pkg::div_step(ds5);
      for (int k = 1; k < CB; k++) begin
        dst[k] <= rhc_pkg::div_step(dst[k-1]);
      end
    end
  end

  always_comb begin
    if (dst[CB-1].func == rhc_pkg::FUNC_TO_RGB) begin
      out_next.res_a = dst[CB-1].r;
      out_next.res_b = dst[CB-1].g;
      out_next.res_c = dst[CB-1].b;
    end else begin
      out_next.res_a = dst[CB-1].h_zero ? '0 : dst[CB-1].h_q;
      out_next.res_b = dst[CB-1].s_zero ? '0 : dst[CB-1].s_q;
      out_next.res_c = dst[CB-1].v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dvalid[CB-1];
    end
    if (advance) begin
      out_data <= out_next;
      out_func <= dst[CB-1].func;
    end
  end

  assign hsv_black = out_valid && (out_func == rhc_pkg::FUNC_TO_HSV) &&
                     (out_data.res_c == '0);

  `RHC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid1)
  `RHC_ASSERT_NEXT(a_stall_freezes_tail, out_valid && out_stall, $stable({dvalid[CB-1], dst[CB-1]}))
  `RHC_ASSERT_NOW(a_black_no_sat, hsv_black, out_data.res_b == '0)

endmodule
